### src/shared_buffer_multi_queue_macros.svh
// Assertion macros for the shared buffer multi-queue checker.
// Depends on nothing; clk_i and rst_ni must exist where the macros are used.
`ifndef SHARED_BUFFER_MULTI_QUEUE_MACROS_SVH
`define SHARED_BUFFER_MULTI_QUEUE_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define SBMQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked property that must also hold during reset.
`define SBMQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/sbmq_pkg.sv
// Shared definitions for the shared buffer multi-queue: default sizes,
// command and status codes. Depends on nothing.
`default_nettype none

package sbmq_pkg;

  // Default sizes
  localparam int unsigned SLOTS_DEF  = 64;
  localparam int unsigned QUEUES_DEF = 4;

  // Command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DROP  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

### src/sbmq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Read data holds while no read is issued. Depends on nothing.
`default_nettype none

module sbmq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### src/shared_buffer_multi_queue.sv
// Shared buffer multi-queue: QUEUES linked-list FIFOs over one slot store.
// Depends on sbmq_pkg and sbmq_ram.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one command per transaction:
//   command_i (0 enqueue, 1 dequeue), queue_id_i (taken modulo QUEUES) and
//   data_in_i. Output channel (out_valid_o/out_ready_i) returns exactly one
//   result per command: data_out_o, status_o (ok, dropped on full pool,
//   dequeue from empty queue), queue_empty_o and pool_full_o.
// Sequencing:
//   One command is in flight at a time. An enqueue or a dequeue from an empty
//   queue registers its result from the look-up state; a successful dequeue
//   registers it from a further dequeue state, since the queue's head pointer
//   must come out of the pointer RAM before the link and data RAMs can be read
//   at that slot. The next command is taken in the cycle after the result is
//   registered.
// Reset:
//   All queues read as empty and every slot is free. The link RAM needs no
//   clearing pass: a high-water mark tracks slots never handed out, whose
//   link is implied as the next slot index.
// Stall:
//   A finished result waits in the output register; a following command is
//   accepted meanwhile and held at its last step until the register frees.
`default_nettype none

module shared_buffer_multi_queue
  import sbmq_pkg::*;
#(
  parameter int unsigned SLOTS  = SLOTS_DEF,
  parameter int unsigned QUEUES = QUEUES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               command_i,
  input  wire logic        [1:0]  queue_id_i,
  input  wire logic signed [31:0] data_in_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed      [31:0] data_out_o,
  output logic             [1:0]  status_o,
  output logic                    queue_empty_o,
  output logic                    pool_full_o
);

  localparam int unsigned PW = $clog2(SLOTS + 1);
  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam logic [PW-1:0] NULL_PTR = PW'(SLOTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_DEQ  = 2'd2;

  // Reduce a queue number modulo QUEUES by repeated subtraction
  function automatic logic [QW-1:0] qmod(input logic [1:0] qid);
    logic [2:0] v;
    v = {1'b0, qid};
    for (int i = 0; i < 3; i++) begin
      if (int'(v) >= int'(QUEUES)) begin
        v = v - 3'(QUEUES);
      end
    end
    return QW'(v);
  endfunction

  logic [1:0]        state_q, state_d;
  logic              cmd_q;
  logic [QW-1:0]     qid_q;
  logic [31:0]       word_q;
  logic [PW-1:0]     hd_q, hd_d, tl_q, tl_d;
  logic [PW-1:0]     free_head_q, free_head_d;
  logic [PW-1:0]     hwm_q, hwm_d;
  logic [QUEUES-1:0] qvld_q;
  logic              out_valid_q, out_valid_d;
  logic signed [31:0] data_out_q, data_out_d;
  logic [1:0]        status_q, status_d;
  logic              qempty_q, qempty_d;
  logic              pfull_q, pfull_d;
  logic              out_load;

  logic              accept, out_free;
  logic [PW-1:0]     cur_head, cur_tail, nxt_free, new_head;

  logic              qp_we, qp_re;
  logic [QW-1:0]     qp_raddr;
  logic [2*PW-1:0]   qp_wdata, qp_rdata;
  logic              ln_we, ln_re;
  logic [AW-1:0]     ln_waddr, ln_raddr;
  logic [PW-1:0]     ln_wdata, ln_rdata;
  logic              dt_we, dt_re;
  logic [AW-1:0]     dt_waddr, dt_raddr;
  logic [31:0]       dt_rdata;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign qp_re      = accept;
  assign qp_raddr   = qmod(queue_id_i);

  // Queue pointers never written since reset read as null
  assign cur_head = qvld_q[qid_q] ? qp_rdata[2*PW-1:PW] : NULL_PTR;
  assign cur_tail = qvld_q[qid_q] ? qp_rdata[PW-1:0]    : NULL_PTR;

  // Next free slot: untouched slots at or above the high-water mark link to s+1
  assign nxt_free = (free_head_q >= hwm_q) ? (free_head_q + PW'(1)) : ln_rdata;
  assign new_head = (hd_q == tl_q) ? NULL_PTR : ln_rdata;

  // Sequence one command through pointer, link and data RAMs
  always_comb begin
    state_d     = state_q;
    hd_d        = hd_q;
    tl_d        = tl_q;
    free_head_d = free_head_q;
    hwm_d       = hwm_q;
    qp_we       = 1'b0;
    qp_wdata    = {cur_head, cur_tail};
    ln_re       = 1'b0;
    ln_raddr    = free_head_q[AW-1:0];
    ln_we       = 1'b0;
    ln_waddr    = cur_tail[AW-1:0];
    ln_wdata    = free_head_q;
    dt_re       = 1'b0;
    dt_raddr    = cur_head[AW-1:0];
    dt_we       = 1'b0;
    dt_waddr    = free_head_q[AW-1:0];
    out_load    = 1'b0;
    data_out_d  = '0;
    status_d    = ST_OK;
    qempty_d    = 1'b0;
    pfull_d     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ln_re   = (command_i == CMD_ENQ) && (free_head_q != NULL_PTR);
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (cmd_q == CMD_ENQ) begin
          if (out_free) begin
            out_load = 1'b1;
            state_d  = S_IDLE;
            if (free_head_q == NULL_PTR) begin
              // Drop the word, pool is full
              status_d = ST_DROP;
              qempty_d = (cur_head == NULL_PTR);
              pfull_d  = 1'b1;
            end else begin
              // Take the free-list head and append it to the queue
              free_head_d = nxt_free;
              if (free_head_q >= hwm_q) begin
                hwm_d = free_head_q + PW'(1);
              end
              dt_we    = 1'b1;
              qp_we    = 1'b1;
              qp_wdata = {(cur_head == NULL_PTR) ? free_head_q : cur_head, free_head_q};
              ln_we    = (cur_head != NULL_PTR);
              ln_wdata = free_head_q;
              pfull_d  = (nxt_free == NULL_PTR);
            end
          end
        end else if (cur_head == NULL_PTR) begin
          if (out_free) begin
            // Dequeue from an empty queue
            out_load = 1'b1;
            status_d = ST_EMPTY;
            qempty_d = 1'b1;
            pfull_d  = (free_head_q == NULL_PTR);
            state_d  = S_IDLE;
          end
        end else begin
          // Fetch link and word of the queue's head slot
          ln_re    = 1'b1;
          ln_raddr = cur_head[AW-1:0];
          dt_re    = 1'b1;
          hd_d     = cur_head;
          tl_d     = cur_tail;
          state_d  = S_DEQ;
        end
      end
      S_DEQ: begin
        if (out_free) begin
          // Unlink the head and push it onto the free list
          qp_we       = 1'b1;
          qp_wdata    = {new_head, (hd_q == tl_q) ? NULL_PTR : tl_q};
          ln_we       = 1'b1;
          ln_waddr    = hd_q[AW-1:0];
          ln_wdata    = free_head_q;
          free_head_d = hd_q;
          out_load    = 1'b1;
          data_out_d  = $signed(dt_rdata);
          qempty_d    = (hd_q == tl_q);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_load || (out_valid_q && !out_ready_i);
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_head_q <= '0;
      hwm_q       <= '0;
      qvld_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      hwm_q       <= hwm_d;
      out_valid_q <= out_valid_d;
      if (qp_we) begin
        qvld_q[qid_q] <= 1'b1;
      end
    end
  end

  // Command and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= command_i;
      qid_q  <= qp_raddr;
      word_q <= data_in_i;
    end
    hd_q <= hd_d;
    tl_q <= tl_d;
    if (out_load) begin
      data_out_q <= data_out_d;
      status_q   <= status_d;
      qempty_q   <= qempty_d;
      pfull_q    <= pfull_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign data_out_o    = data_out_q;
  assign status_o      = status_q;
  assign queue_empty_o = qempty_q;
  assign pool_full_o   = pfull_q;

  // Per-queue head and tail pointers
  sbmq_ram #(
    .WIDTH (2 * PW),
    .DEPTH (QUEUES)
  ) u_qptr_ram (
    .clk_i   (clk_i),
    .we_i    (qp_we),
    .waddr_i (qid_q),
    .wdata_i (qp_wdata),
    .re_i    (qp_re),
    .raddr_i (qp_raddr),
    .rdata_o (qp_rdata)
  );

  // Slot links shared by the free list and all queues
  sbmq_ram #(
    .WIDTH (PW),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ln_we),
    .waddr_i (ln_waddr),
    .wdata_i (ln_wdata),
    .re_i    (ln_re),
    .raddr_i (ln_raddr),
    .rdata_o (ln_rdata)
  );

  // Slot data words
  sbmq_ram #(
    .WIDTH (32),
    .DEPTH (SLOTS)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (dt_we),
    .waddr_i (dt_waddr),
    .wdata_i (word_q),
    .re_i    (dt_re),
    .raddr_i (dt_raddr),
    .rdata_o (dt_rdata)
  );

endmodule

`default_nettype wire

### src/sbmq_checker.sv
// Port-level checker for the shared buffer multi-queue, bound to the top level.
// Depends on sbmq_pkg and shared_buffer_multi_queue_macros.svh.
`include "shared_buffer_multi_queue_macros.svh"
`default_nettype none

module sbmq_checker
  import sbmq_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic signed [31:0] data_out_o,
  input wire logic        [1:0]  status_o,
  input wire logic               queue_empty_o,
  input wire logic               pool_full_o
);

  logic drop_res, empty_res;

  // Classify the result on offer
  assign drop_res  = out_valid_o && (status_o == ST_DROP);
  assign empty_res = out_valid_o && (status_o == ST_EMPTY);

  // Hold a result until it is taken
  `SBMQ_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result lost in stall")

  // One command in flight: no acceptance in the cycle after a transaction
  `SBMQ_ASSERT(a_one_in_flight, in_valid_i && in_ready_o |=> !in_ready_o, "back-to-back accept")

  // A dropped enqueue means the pool is full
  `SBMQ_ASSERT(a_drop_full, drop_res |-> pool_full_o, "drop without full pool")

  // A failed dequeue reports an empty queue and a zero word
  `SBMQ_ASSERT(a_empty_deq, empty_res |-> queue_empty_o && (data_out_o == 0), "bad empty dequeue")

endmodule

bind shared_buffer_multi_queue sbmq_checker u_sbmq_checker (.*);

`default_nettype wire
